/* design/fcb_pkg.sv */
// ----------------------------------------------------------------------------
// fcb_pkg
// Shared types, sizes and codes of the frame-coalescing transmit buffer.
// ----------------------------------------------------------------------------
package fcb_pkg;

  localparam int BufferBytes = 240;
  localparam int PacketBytes = 64;
  // byte ring: logical fill plus up to four packets still being read out
  localparam int MemDepth    = 512;
  localparam int MemAw       = $clog2(MemDepth);
  localparam int CntW        = $clog2(BufferBytes + 1);
  localparam int ChunkW      = $clog2(PacketBytes + 1);
  localparam int CmdDepth    = 2;
  localparam int CmdAw       = $clog2(CmdDepth);
  localparam int CmdCntW     = $clog2(CmdDepth + 1);
  localparam int OutDepth    = 4;
  localparam int OutAw       = $clog2(OutDepth);
  localparam int OutCntW     = $clog2(OutDepth + 1);
  localparam int FrameLenW   = 3;

  localparam logic [FrameLenW-1:0] StampLen  = 3'd6;
  localparam logic [FrameLenW-1:0] SampleLen = 3'd4;

  localparam logic [15:0] TsIntervalRst = 16'd1000;
  localparam logic [15:0] DividerRst    = 16'd1;
  localparam logic [7:0]  ThresholdRst  = 8'd240;
  localparam logic [15:0] TimeoutRst    = 16'd1;

  typedef enum logic [1:0] {
    CFG_TS_INTERVAL = 2'd0,
    CFG_DIVIDER     = 2'd1,
    CFG_THRESHOLD   = 2'd2,
    CFG_TIMEOUT     = 2'd3
  } fcb_cfg_idx_e;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_CALC_A,
    FR_CALC_B,
    FR_WRITE,
    FR_CMD
  } fcb_front_state_e;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        link_busy;
    logic [31:0] sample_frame;
    logic [47:0] stamp_frame;
  } fcb_in_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_of_packet;
  } fcb_out_t;

  typedef struct packed {
    logic [MemAw-1:0]  start;
    logic [ChunkW-1:0] len;
  } fcb_cmd_t;

  typedef struct packed {
    logic             en;
    logic [MemAw-1:0] addr;
    logic [7:0]       data;
  } fcb_wr_t;

  function automatic logic [ChunkW-1:0] chunk_of(input logic [CntW-1:0] cnt);
    if (cnt >= CntW'(PacketBytes)) begin
      return ChunkW'(PacketBytes);
    end
    return ChunkW'(cnt);
  endfunction

endpackage

/* design/fcb_front.sv */
// ----------------------------------------------------------------------------
// fcb_front
// Step sequencer: takes one service step, decides frame queuing and packet
// release, writes frame bytes into the ring and posts packet commands.
// ----------------------------------------------------------------------------
module fcb_front import fcb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fcb_in_t          in_item_i,
  output logic             full_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  fcb_cfg_idx_e     cfg_index_i,
  input  logic [15:0]      cfg_data_i,
  output fcb_wr_t          wr_o,
  output logic             cmd_push_o,
  output fcb_cmd_t         cmd_o,
  input  logic             cmdq_full_i
);

  fcb_front_state_e state_q, state_d;

  logic [15:0] ts_int_q, div_q, tmo_q;
  logic [7:0]  thr_q;

  logic [CntW-1:0]  cnt_q;
  logic             forced_q;
  logic [31:0]      start_ms_q;
  logic [15:0]      fss_q, divc_q;
  logic [MemAw-1:0] head_q;

  logic [31:0]      now_q;
  logic             busy_q, age_ge_q, is_stamp_q;
  logic [47:0]      frame_q;

  logic [CntW-1:0]   cnt_a_q;
  logic              forced_a_q, restart_a_q, sent_a_q, fits_q, zero_fss_q;
  logic [ChunkW-1:0] chunk_a_q;
  logic [MemAw-1:0]  wr_base_q;

  logic              sent_q;
  logic [MemAw-1:0]  pkt_start_q;
  logic [ChunkW-1:0] pkt_len_q;
  logic [FrameLenW-1:0] wr_idx_q;

  logic                 accept;
  logic [FrameLenW-1:0] flen;

  // first half of the step: early release and overflow handling
  logic [ChunkW-1:0] chunk0;
  logic [CntW-1:0]   cnt1, cnt2;
  logic              send1, sendq, over1, fits, attempt, div_hit, forced2, restart_a;
  logic [15:0]       divc_inc, fss_n;

  // second half: flush flags and late release
  logic [CntW-1:0]   cnt3, cnt4;
  logic [ChunkW-1:0] chunk3;
  logic              age_eff, forced3, send3;

  assign accept      = push_i && !full_o;
  assign cfg_ready_o = 1'b1;
  assign flen        = is_stamp_q ? StampLen : SampleLen;

  always_comb begin
    chunk0   = chunk_of(cnt_q);
    send1    = !busy_q && (cnt_q != '0) && (forced_q || (cnt_q >= thr_q));
    cnt1     = send1 ? (cnt_q - CntW'(chunk0)) : cnt_q;
    divc_inc = divc_q + 16'd1;
    div_hit  = divc_inc >= div_q;
    attempt  = is_stamp_q || div_hit;
    over1    = attempt && (({1'b0, cnt1} + (CntW+1)'(flen)) > (CntW+1)'(BufferBytes));
    sendq    = over1 && !send1 && !busy_q && (cnt1 != '0);
    cnt2     = sendq ? (cnt1 - CntW'(chunk0)) : cnt1;
    forced2  = forced_q;
    if (send1 && (cnt1 == '0)) begin
      forced2 = 1'b0;
    end
    if (over1) begin
      forced2 = 1'b1;
    end
    if (sendq && (cnt2 == '0)) begin
      forced2 = 1'b0;
    end
    fits      = attempt && (({1'b0, cnt2} + (CntW+1)'(flen)) <= (CntW+1)'(BufferBytes));
    restart_a = (send1 && (cnt1 != '0)) || (sendq && (cnt2 != '0)) ||
                (fits && (cnt2 == '0));
    fss_n     = fits ? (is_stamp_q ? 16'd0 : (fss_q + 16'd1)) : fss_q;
  end

  always_comb begin
    cnt3    = cnt_a_q + (fits_q ? CntW'(flen) : CntW'(0));
    // a fill time restarted in this step has age zero
    age_eff = restart_a_q ? (tmo_q == 16'd0) : age_ge_q;
    forced3 = forced_a_q || (cnt3 >= thr_q) || ((cnt3 != '0) && age_eff) || zero_fss_q;
    send3   = !sent_a_q && !busy_q && (cnt3 != '0) && (forced3 || (cnt3 >= thr_q));
    chunk3  = chunk_of(cnt3);
    cnt4    = send3 ? (cnt3 - CntW'(chunk3)) : cnt3;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    full_o     = 1'b1;
    cmd_push_o = 1'b0;
    wr_o.en    = 1'b0;
    wr_o.addr  = wr_base_q + MemAw'(wr_idx_q);
    wr_o.data  = frame_q[7:0];
    unique case (state_q)
      FR_IDLE: begin
        full_o = cmdq_full_i;
        if (push_i && !cmdq_full_i) begin
          state_d = FR_CALC_A;
        end
      end
      FR_CALC_A: state_d = FR_CALC_B;
      FR_CALC_B: state_d = fits_q ? FR_WRITE : FR_CMD;
      FR_WRITE: begin
        wr_o.en = 1'b1;
        if (wr_idx_q == flen - FrameLenW'(1)) begin
          state_d = FR_CMD;
        end
      end
      FR_CMD: begin
        cmd_push_o = sent_q;
        state_d    = FR_IDLE;
      end
      default: state_d = FR_IDLE;
    endcase
  end

  assign cmd_o.start = pkt_start_q;
  assign cmd_o.len   = pkt_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_int_q <= TsIntervalRst;
      div_q    <= DividerRst;
      thr_q    <= ThresholdRst;
      tmo_q    <= TimeoutRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_TS_INTERVAL: ts_int_q <= cfg_data_i;
        CFG_DIVIDER:     div_q    <= cfg_data_i;
        CFG_THRESHOLD:   thr_q    <= cfg_data_i[7:0];
        CFG_TIMEOUT:     tmo_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // architectural buffer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      forced_q   <= 1'b0;
      start_ms_q <= '0;
      fss_q      <= '0;
      divc_q     <= '0;
      head_q     <= '0;
      sent_q     <= 1'b0;
    end else begin
      if (state_q == FR_CALC_A) begin
        fss_q <= fss_n;
        if (!is_stamp_q) begin
          divc_q <= div_hit ? 16'd0 : divc_inc;
        end
      end
      if (state_q == FR_CALC_B) begin
        cnt_q    <= cnt4;
        forced_q <= (send3 && (cnt4 == '0)) ? 1'b0 : forced3;
        if (restart_a_q || (send3 && (cnt4 != '0))) begin
          start_ms_q <= now_q;
        end
        sent_q <= sent_a_q || send3;
        if (sent_a_q) begin
          head_q <= head_q + MemAw'(chunk_a_q);
        end else if (send3) begin
          head_q <= head_q + MemAw'(chunk3);
        end
      end
    end
  end

  // per-step working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q      <= in_item_i.now_ms;
      busy_q     <= in_item_i.link_busy;
      age_ge_q   <= (in_item_i.now_ms - start_ms_q) >= {16'd0, tmo_q};
      is_stamp_q <= fss_q >= ts_int_q;
      frame_q    <= (fss_q >= ts_int_q) ? in_item_i.stamp_frame
                                        : {16'd0, in_item_i.sample_frame};
    end
    if (state_q == FR_CALC_A) begin
      cnt_a_q     <= cnt2;
      forced_a_q  <= forced2;
      restart_a_q <= restart_a;
      sent_a_q    <= send1 || sendq;
      chunk_a_q   <= chunk0;
      fits_q      <= fits;
      zero_fss_q  <= fits && (fss_n == 16'd0);
      // ring tail does not move with a release
      wr_base_q   <= head_q + MemAw'(cnt_q);
      wr_idx_q    <= '0;
    end
    if (state_q == FR_CALC_B) begin
      pkt_start_q <= head_q;
      pkt_len_q   <= sent_a_q ? chunk_a_q : chunk3;
    end
    if (state_q == FR_WRITE) begin
      frame_q  <= frame_q >> 8;
      wr_idx_q <= wr_idx_q + FrameLenW'(1);
    end
  end

  a_cmd_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FR_CMD && sent_q) |-> !cmdq_full_i)
    else $error("packet command posted into a full queue");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(BufferBytes))
    else $error("fill count above buffer size");

  a_pkt_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FR_CALC_B && (sent_a_q || send3)) |=>
      (pkt_len_q != '0) && (pkt_len_q <= ChunkW'(PacketBytes)))
    else $error("released packet has bad length");

endmodule

/* design/fcb_cmd_queue.sv */
// ----------------------------------------------------------------------------
// fcb_cmd_queue
// Short queue of packet commands between the step sequencer and the sender.
// ----------------------------------------------------------------------------
module fcb_cmd_queue import fcb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  fcb_cmd_t data_i,
  output logic     full_o,
  output logic     valid_o,
  output fcb_cmd_t data_o,
  input  logic     pop_i
);

  fcb_cmd_t           slot_q [CmdDepth];
  logic [CmdAw-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CmdCntW-1:0] cnt_q;
  logic               do_push, do_pop;

  assign full_o  = cnt_q == CmdCntW'(CmdDepth);
  assign valid_o = cnt_q != '0;
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == CmdAw'(CmdDepth - 1)) ? '0 : wr_ptr_q + CmdAw'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == CmdAw'(CmdDepth - 1)) ? '0 : rd_ptr_q + CmdAw'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CmdCntW'(1);
        2'b01:   cnt_q <= cnt_q - CmdCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* design/fcb_back.sv */
// ----------------------------------------------------------------------------
// fcb_back
// Byte ring and packet sender: reads released packets out of the ring one
// byte per cycle, while the result queue has room, into a small result queue.
// ----------------------------------------------------------------------------
module fcb_back import fcb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  fcb_wr_t  wr_i,
  input  logic     cmd_valid_i,
  input  fcb_cmd_t cmd_i,
  output logic     cmd_pop_o,
  input  logic     pop_i,
  output logic     empty_o,
  output fcb_out_t out_item_o
);

  logic [7:0] ring_q [MemDepth];

  logic              active_q;
  logic [MemAw-1:0]  addr_q;
  logic [ChunkW-1:0] left_q;
  logic              rd_go;
  logic              rd_vld_q, rd_last_q;
  logic [7:0]        rd_data_q;

  fcb_out_t           ofifo_q [OutDepth];
  logic [OutAw-1:0]   owr_q, ord_q;
  logic [OutCntW-1:0] ocnt_q;
  logic               opop;

  assign cmd_pop_o = cmd_valid_i && !active_q;
  // keep room for the read already in the memory pipe
  assign rd_go     = active_q && ((ocnt_q + OutCntW'(rd_vld_q)) < OutCntW'(OutDepth));
  assign empty_o   = ocnt_q == '0;
  assign opop      = pop_i && !empty_o;
  assign out_item_o = ofifo_q[ord_q];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      ring_q[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= ring_q[addr_q];
    rd_last_q <= left_q == ChunkW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      addr_q   <= '0;
      left_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_go;
      if (cmd_pop_o) begin
        active_q <= 1'b1;
        addr_q   <= cmd_i.start;
        left_q   <= cmd_i.len;
      end else if (rd_go) begin
        addr_q <= addr_q + MemAw'(1);
        left_q <= left_q - ChunkW'(1);
        if (left_q == ChunkW'(1)) begin
          active_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= '0;
      ord_q  <= '0;
      ocnt_q <= '0;
    end else begin
      if (rd_vld_q) begin
        owr_q <= owr_q + OutAw'(1);
      end
      if (opop) begin
        ord_q <= ord_q + OutAw'(1);
      end
      case ({rd_vld_q, opop})
        2'b10:   ocnt_q <= ocnt_q + OutCntW'(1);
        2'b01:   ocnt_q <= ocnt_q - OutCntW'(1);
        default: ocnt_q <= ocnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      ofifo_q[owr_q] <= '{tx_byte: rd_data_q, last_of_packet: rd_last_q};
    end
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (ocnt_q < OutCntW'(OutDepth)))
    else $error("result queue overrun");

  a_active_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (left_q != '0))
    else $error("sender active with no bytes left");

  a_ocnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q <= OutCntW'(OutDepth))
    else $error("result queue count out of range");

endmodule

/* design/frame_coalescing_tx_buffer.sv */
// ----------------------------------------------------------------------------
// frame_coalescing_tx_buffer
// Buffers sample and timestamp frames and releases them as packets of up to
// 64 bytes, one byte per result item.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+----------------------------
//  step     | in        | push / full             | in_item_i  (fcb_in_t)
//  result   | out       | pop / empty             | out_item_o (fcb_out_t)
//  config   | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A step passes the sequencer through FR_CALC_A, FR_CALC_B, FR_WRITE (the 4
// or 6 bytes of a sample or timestamp frame into the byte ring, one write
// port; skipped if the frame does not fit) and FR_CMD. Packet bytes leave
// at one per cycle from the ring read port while the result queue has room.
// full is high while a step is worked or both command slots are taken; a
// stalled pop stops the sender, and the sequencer once the slots fill.
// Reset clears all control state; the ring holds no valid bits.
module frame_coalescing_tx_buffer import fcb_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push,
  output logic         full,
  input  fcb_in_t      in_item_i,
  output logic         empty,
  input  logic         pop,
  output fcb_out_t     out_item_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  fcb_cfg_idx_e cfg_index_i,
  input  logic [15:0]  cfg_data_i
);

  fcb_wr_t  wr;
  fcb_cmd_t cmd_in, cmd_out;
  logic     cmd_push, cmd_full, cmd_valid, cmd_pop;

  fcb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .in_item_i   (in_item_i),
    .full_o      (full),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .wr_o        (wr),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in),
    .cmdq_full_i (cmd_full)
  );

  fcb_cmd_queue u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .valid_o (cmd_valid),
    .data_o  (cmd_out),
    .pop_i   (cmd_pop)
  );

  fcb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_item_o  (out_item_o)
  );

endmodule
